>>> src/hgps_pkg.sv
package hgps_pkg;

  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned SQRT_STEPS    = 32;
  localparam int unsigned DIV_STEPS     = 32;

  // One command word per cycle from the controller to the datapath
  typedef struct packed {
    logic       load;       // capture an input word
    logic       sq;         // square one coordinate, build the sum
    logic       norm_init;  // start root of the sum of squares
    logic       sqrt_step;  // one digit of the shared root unit
    logic       num;        // one partial product of the weighted sum
    logic       div_init;   // save norm, start the division
    logic       div_step;   // one quotient bit
    logic       sig_init;   // start root of the scaled quotient
    logic       lim;        // form the limit and compare
    logic       side;       // 0 robot, 1 operator
    logic [2:0] idx;        // axis, or axis and half for partial products
  } hgps_cmd_t;

  typedef struct packed {
    logic robot_below;
    logic oper_above;
  } hgps_stat_t;

endpackage

>>> src/hgps_datapath.sv
module hgps_datapath
  import hgps_pkg::*;
(
  input  logic             clk,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,
  input  logic             rst_n,
  input  hgps_cmd_t        cmd,
  input  logic [31:0]      pos_in [6],
  input  logic [31:0]      var_in [6],
  output hgps_stat_t       stat
);

  logic [31:0] md_r;
  logic [31:0] pos_r [6];
  logic [31:0] var_r [6];
  logic [62:0] sq_r [3];
  logic [63:0] sum_r;
  logic [95:0] acc_r;
  logic [63:0] dr_r;
  logic [31:0] q_r;
  logic [63:0] rad_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [31:0] norm_r;
  logic        robot_below_r;
  logic        oper_above_r;

  logic [2:0]  sel;
  logic [1:0]  axis;
  logic [31:0] p;
  logic [31:0] mag;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [35:0] rem_t;
  logic [35:0] trial;
  logic        sq_ge;
  logic [64:0] div_t;
  logic        div_ge;
  logic [31:0] sigma;
  logic signed [34:0] lim;
  logic signed [34:0] md_s;

  assign axis  = (cmd.num) ? cmd.idx[2:1] : cmd.idx[1:0];
  assign sel   = cmd.side ? (3'd3 + {1'b0, axis}) : {1'b0, axis};
  assign p     = pos_r[sel];
  assign mag   = p[31] ? (32'd0 - p) : p;

  always_comb begin
    if (cmd.num) begin
      mul_a = cmd.idx[0] ? {1'b0, sq_r[axis][62:32]} : sq_r[axis][31:0];
      mul_b = var_r[sel];
    end else begin
      mul_a = mag;
      mul_b = mag;
    end
  end

  assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

  assign rem_t = {rem_r, rad_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};
  assign sq_ge = (rem_t >= trial);

  assign div_t  = {dr_r, acc_r[31]};
  assign div_ge = (div_t >= {1'b0, sum_r});

  assign sigma = (sum_r == 64'd0) ? 32'd0 : root_r;
  assign lim   = $signed({3'b000, norm_r}) - $signed({2'b00, sigma, 1'b0});
  assign md_s  = $signed({3'b000, md_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_r <= 32'd0;
    end else if (cfg_wr_en) begin
      md_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r <= pos_in;
      var_r <= var_in;
    end
    if (cmd.sq) begin
      sq_r[axis] <= prod[62:0];
      sum_r      <= (axis == 2'd0) ? prod : (sum_r + prod);
    end
    if (cmd.num) begin
      if (cmd.idx == 3'd0) begin
        acc_r <= {32'd0, prod};
      end else if (cmd.idx[0]) begin
        acc_r <= acc_r + {prod, 32'd0};
      end else begin
        acc_r <= acc_r + {32'd0, prod};
      end
    end
    if (cmd.norm_init) begin
      rad_r  <= sum_r;
      rem_r  <= 34'd0;
      root_r <= 32'd0;
    end
    if (cmd.sig_init) begin
      rad_r  <= {32'd0, q_r} << FRACTION_BITS;
      rem_r  <= 34'd0;
      root_r <= 32'd0;
    end
    if (cmd.sqrt_step) begin
      rad_r  <= {rad_r[61:0], 2'b00};
      rem_r  <= sq_ge ? 34'(rem_t - trial) : rem_t[33:0];
      root_r <= {root_r[30:0], sq_ge};
    end
    if (cmd.div_init) begin
      norm_r <= root_r;
      dr_r   <= acc_r[95:32];
    end
    if (cmd.div_step) begin
      dr_r  <= div_ge ? 64'(div_t - {1'b0, sum_r}) : div_t[63:0];
      q_r   <= {q_r[30:0], div_ge};
      acc_r <= {acc_r[95:32], acc_r[30:0], 1'b0};
    end
    if (cmd.lim) begin
      if (cmd.side) begin
        oper_above_r  <= (lim > md_s);
      end else begin
        robot_below_r <= (lim < md_s);
      end
    end
  end

  assign stat.robot_below = robot_below_r;
  assign stat.oper_above  = oper_above_r;

endmodule

>>> src/hgps_ctrl.sv
module hgps_ctrl
  import hgps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_request_kind,
  output logic       out_request_value,
  output logic       out_last_of_run,
  output hgps_cmd_t  cmd,
  input  hgps_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_NINIT, S_NSTEP, S_NUM, S_DINIT, S_DSTEP,
    S_SINIT, S_SSTEP, S_LIM, S_DECIDE, S_EMIT_STOP, S_EMIT_MODE, S_EMIT_RES
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        side_r, side_nxt;
  logic        manual_r, manual_nxt;
  logic        stopped_r, stopped_nxt;
  logic        ov_r, ov_nxt;
  logic        kind_r, kind_nxt;
  logic        val_r, val_nxt;
  logic        last_r, last_nxt;
  logic        out_free;
  logic        flip;

  assign out_free = !ov_r || !out_stall;
  assign flip     = (stat.robot_below && !manual_r) || (stat.oper_above && manual_r);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    side_nxt    = side_r;
    manual_nxt  = manual_r;
    stopped_nxt = stopped_r;
    ov_nxt      = ov_r && out_stall;
    kind_nxt    = kind_r;
    val_nxt     = val_r;
    last_nxt    = last_r;
    cmd         = '0;
    cmd.side    = side_r;
    cmd.idx     = cnt_r[2:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          side_nxt  = 1'b0;
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq  = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd2) begin
          state_nxt = S_NINIT;
        end
      end
      S_NINIT: begin
        cmd.norm_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_NSTEP;
      end
      S_NSTEP: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 6'd1;
        if (cnt_r == 6'(SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_NUM;
        end
      end
      S_NUM: begin
        cmd.num = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd5) begin
          state_nxt = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_STEPS - 1)) begin
          state_nxt = S_SINIT;
        end
      end
      S_SINIT: begin
        cmd.sig_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_SSTEP;
      end
      S_SSTEP: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 6'd1;
        if (cnt_r == 6'(SQRT_STEPS - 1)) begin
          state_nxt = S_LIM;
        end
      end
      S_LIM: begin
        cmd.lim = 1'b1;
        cnt_nxt = '0;
        if (side_r) begin
          state_nxt = S_DECIDE;
        end else begin
          side_nxt  = 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_DECIDE: begin
        if (flip) begin
          manual_nxt  = !manual_r;
          stopped_nxt = 1'b1;
          state_nxt   = S_EMIT_STOP;
        end else if (stopped_r) begin
          stopped_nxt = 1'b0;
          state_nxt   = S_EMIT_RES;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT_STOP: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          kind_nxt  = 1'b0;
          val_nxt   = 1'b1;
          last_nxt  = 1'b0;
          state_nxt = S_EMIT_MODE;
        end
      end
      S_EMIT_MODE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          kind_nxt  = 1'b1;
          val_nxt   = manual_r;
          last_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT_RES: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          kind_nxt  = 1'b0;
          val_nxt   = 1'b0;
          last_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      side_r    <= 1'b0;
      manual_r  <= 1'b0;
      stopped_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      side_r    <= side_nxt;
      manual_r  <= manual_nxt;
      stopped_r <= stopped_nxt;
      ov_r      <= ov_nxt;
    end
    kind_r <= kind_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = ov_r;
  assign out_request_kind  = kind_r;
  assign out_request_value = val_r;
  assign out_last_of_run   = last_r;

endmodule

>>> src/hand_guiding_proximity_supervisor.sv
// Hand-guiding proximity supervisor.
// Input channel: in_valid / in_stall carrying one robot and one operator
// position (signed Q16.16) with per-axis variances. A word is taken when
// in_valid is high and in_stall is low; in_stall stays high while a word
// is being worked on and until its requests are in the output register.
// Output channel: out_valid / out_stall carrying request words
// (kind, value, last_of_run); zero, one or two words per input word.
// Compute: for each side the coordinates are squared and summed, and the
// shared root unit (32 steps, used four times) and the shift-subtract
// divider (32 steps, used twice) form the norm and sigma; the block then
// decides and loads the output register. A second request word, if any,
// follows once the output register is free.
// cfg_wr_en / cfg_wr_data write min_distance; write only while idle.
// Reset (rst_n low, synchronous) clears min_distance, puts the block in
// automatic mode, not stopped, and drops out_valid.
// A stalled receiver holds the request word; the block waits with the next
// request word until the output register is free.
module hand_guiding_proximity_supervisor
  import hgps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_robot_x,
  input  logic [31:0] in_robot_y,
  input  logic [31:0] in_robot_z,
  input  logic [31:0] in_robot_var_x,
  input  logic [31:0] in_robot_var_y,
  input  logic [31:0] in_robot_var_z,
  input  logic [31:0] in_operator_x,
  input  logic [31:0] in_operator_y,
  input  logic [31:0] in_operator_z,
  input  logic [31:0] in_operator_var_x,
  input  logic [31:0] in_operator_var_y,
  input  logic [31:0] in_operator_var_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_request_kind,
  output logic        out_request_value,
  output logic        out_last_of_run
);

  hgps_cmd_t   cmd;
  hgps_stat_t  stat;
  logic [31:0] pos_in [6];
  logic [31:0] var_in [6];

  assign pos_in = '{in_robot_x, in_robot_y, in_robot_z,
                    in_operator_x, in_operator_y, in_operator_z};
  assign var_in = '{in_robot_var_x, in_robot_var_y, in_robot_var_z,
                    in_operator_var_x, in_operator_var_y, in_operator_var_z};

  hgps_datapath u_dp (
    .clk         (clk),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .pos_in      (pos_in),
    .var_in      (var_in),
    .stat        (stat)
  );

  hgps_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_request_kind  (out_request_kind),
    .out_request_value (out_request_value),
    .out_last_of_run   (out_last_of_run),
    .cmd               (cmd),
    .stat              (stat)
  );

`ifndef NO_ASSERTIONS
  a_stop_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> !out_request_kind && out_request_value)
    else $error("non-final word is not a stop request");

  a_override_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_request_kind |-> out_last_of_run)
    else $error("override request not final");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");
`endif

endmodule

>>> bench/tb_hand_guiding_proximity_supervisor.sv
`timescale 1ns / 1ps

module tb_hand_guiding_proximity_supervisor;
  import hgps_pkg::*;

  localparam logic KIND_STOP     = 1'b0;
  localparam logic KIND_OVERRIDE = 1'b1;
  localparam int   N_RANDOM      = 1830;
  localparam int   SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [31:0] rx, ry, rz, rvx, rvy, rvz;
    logic [31:0] ox, oy, oz, ovx, ovy, ovz;
  } pose_pair_t;

  typedef struct packed {
    logic kind;
    logic value;
    logic last;
  } request_t;

  typedef struct {
    pose_pair_t pose;
    bit         typed;
    int         n_req;
    request_t   req0, req1;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pose_pair_t  pose_drv = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_request_kind, out_request_value, out_last_of_run;

  request_t    pending_requests[$];
  logic [31:0] min_dist_shadow;
  logic        manual_shadow, stopped_shadow;
  bit          in_idle_en, out_idle_en;
  int          errs = 0;

  hand_guiding_proximity_supervisor u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_robot_x(pose_drv.rx), .in_robot_y(pose_drv.ry), .in_robot_z(pose_drv.rz),
    .in_robot_var_x(pose_drv.rvx), .in_robot_var_y(pose_drv.rvy),
    .in_robot_var_z(pose_drv.rvz),
    .in_operator_x(pose_drv.ox), .in_operator_y(pose_drv.oy),
    .in_operator_z(pose_drv.oz),
    .in_operator_var_x(pose_drv.ovx), .in_operator_var_y(pose_drv.ovy),
    .in_operator_var_z(pose_drv.ovz),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_request_kind(out_request_kind), .out_request_value(out_request_value),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #40ms;
    $display("tb_hand_guiding_proximity_supervisor: done, errors");
    $finish;
  end

  function automatic logic [63:0] int_root(input logic [63:0] v);
    logic [63:0] res, b;
    res = '0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - res - b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] coord_sq(input logic [31:0] p);
    logic [32:0] m;
    m = p[31] ? (33'h1_0000_0000 - {1'b0, p}) : {1'b0, p};
    return {31'b0, m} * {31'b0, m};
  endfunction

  // norm - 2*sigma, sigma from variance weighted by squared coordinates
  function automatic logic signed [63:0] safe_limit(
      input logic [31:0] x, y, z, vx, vy, vz);
    logic [63:0]  s0, s1, s2, total, norm, sigma;
    logic [127:0] wsum, quot;
    s0 = coord_sq(x);
    s1 = coord_sq(y);
    s2 = coord_sq(z);
    total = s0 + s1 + s2;
    norm = int_root(total);
    sigma = '0;
    if (total != 0) begin
      wsum = {64'b0, s0} * {96'b0, vx} + {64'b0, s1} * {96'b0, vy}
           + {64'b0, s2} * {96'b0, vz};
      quot = wsum / {64'b0, total};
      sigma = int_root({16'b0, quot[31:0], 16'b0});
    end
    return $signed(norm) - 2 * $signed(sigma);
  endfunction

  // advance the supervisor state for one pose pair; returns the requests
  function automatic int supervise(input pose_pair_t p, output request_t r0,
                                   output request_t r1);
    logic signed [63:0] r_lim, o_lim, md;
    r_lim = safe_limit(p.rx, p.ry, p.rz, p.rvx, p.rvy, p.rvz);
    o_lim = safe_limit(p.ox, p.oy, p.oz, p.ovx, p.ovy, p.ovz);
    md = $signed({32'b0, min_dist_shadow});
    r0 = '0;
    r1 = '0;
    if ((r_lim < md && !manual_shadow) || (o_lim > md && manual_shadow)) begin
      stopped_shadow = 1'b1;
      manual_shadow = !manual_shadow;
      r0 = '{KIND_STOP, 1'b1, 1'b0};
      r1 = '{KIND_OVERRIDE, manual_shadow, 1'b1};
      return 2;
    end
    if (stopped_shadow) begin
      stopped_shadow = 1'b0;
      r0 = '{KIND_STOP, 1'b0, 1'b1};
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    out_stall <= out_idle_en && ($urandom_range(99) < 28);
  end

  always @(posedge clk) begin
    request_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_requests.size() == 0) begin
        $error("request word with none pending");
        errs++;
      end else begin
        want = pending_requests.pop_front();
        if (out_request_kind !== want.kind) begin
          $error("request_kind: expected %0b, got %0b", want.kind, out_request_kind);
          errs++;
        end
        if (out_request_value !== want.value) begin
          $error("request_value: expected %0b, got %0b", want.value, out_request_value);
          errs++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_last_of_run);
          errs++;
        end
      end
    end
  end

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_pose(input stim_row_t row);
    request_t p0, p1;
    int n;
    pose_drv <= row.pose;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = supervise(row.pose, p0, p1);
    if (row.typed) begin
      n = row.n_req;
      p0 = row.req0;
      p1 = row.req1;
    end
    if (n > 0) pending_requests.push_back(p0);
    if (n > 1) pending_requests.push_back(p1);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_requests.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_distance(input logic [31:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    min_dist_shadow = v;
  endtask

  function automatic logic [31:0] near_coord();
    if ($urandom_range(9) == 0) return '0;
    return $urandom_range(32'h0003_0000 * 2) - 32'h0003_0000;
  endfunction

  function automatic logic [31:0] near_var();
    return ($urandom_range(7) == 0) ? $urandom() : $urandom_range(32'h0000_4000);
  endfunction

  function automatic pose_pair_t random_pose();
    pose_pair_t p;
    if ($urandom_range(99) < 10) begin
      p = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    end else begin
      p = {near_coord(), near_coord(), near_coord(), near_var(), near_var(), near_var(),
           near_coord(), near_coord(), near_coord(), near_var(), near_var(), near_var()};
    end
    return p;
  endfunction

  stim_row_t directed[$];

  function automatic stim_row_t row_of(input pose_pair_t p, input bit typed, input int n,
                                       input request_t a, input request_t b);
    stim_row_t r;
    r.pose = p; r.typed = typed; r.n_req = n; r.req0 = a; r.req1 = b;
    return r;
  endfunction

  initial begin
    logic [31:0] md_steps[5];
    pose_pair_t p;
    int per_phase, k;
    md_steps = '{32'h0000_0000, 32'h0001_8000, 32'hFFFF_FFFF, 32'h0000_8000,
                 32'h0002_0000};
    min_dist_shadow = '0;
    manual_shadow = 1'b0;
    stopped_shadow = 1'b0;
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;

    // min_distance 0, automatic: zero poses give limit 0 and no request
    directed.push_back(row_of('0, 1, 0, '0, '0));
    p = '0; p.rx = 32'h1; p.rvx = 32'hFFFF_FFFF;
    directed.push_back(row_of(p, 1, 2, '{KIND_STOP, 1'b1, 1'b0},
                              '{KIND_OVERRIDE, 1'b1, 1'b1}));
    directed.push_back(row_of('0, 1, 1, '{KIND_STOP, 1'b0, 1'b1}, '0));
    directed.push_back(row_of('0, 1, 0, '0, '0));
    p = '0; p.ox = 32'h7FFF_FFFF;
    directed.push_back(row_of(p, 1, 2, '{KIND_STOP, 1'b1, 1'b0},
                              '{KIND_OVERRIDE, 1'b0, 1'b1}));
    directed.push_back(row_of('1, 0, 0, '0, '0));
    directed.push_back(row_of({12{32'h8000_0000}}, 0, 0, '0, '0));
    directed.push_back(row_of({12{32'h7FFF_FFFF}}, 0, 0, '0, '0));
    directed.push_back(row_of({{6{32'h8000_0000}}, {6{32'hFFFF_FFFF}}}, 0, 0, '0, '0));
    p = '0; p.rx = 32'h8000_0000; p.rvx = 32'hFFFF_FFFF; p.oz = 32'h8000_0000;
    directed.push_back(row_of(p, 0, 0, '0, '0));
    p = '0; p.ry = 32'hFFFF_FFFF; p.rvy = 32'h0001_0000; p.oy = 32'h0001_0000;
    directed.push_back(row_of(p, 0, 0, '0, '0));
    p = '0; p.rz = 32'h0000_0001; p.ox = 32'hFFFF_0000; p.ovx = 32'hFFFF_FFFF;
    directed.push_back(row_of(p, 0, 0, '0, '0));
    directed.push_back(row_of({{3{32'h5555_5555}}, {3{32'hAAAA_AAAA}},
                               {3{32'hAAAA_AAAA}}, {3{32'h5555_5555}}}, 0, 0, '0, '0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_pose(directed[i]);

    per_phase = N_RANDOM / 5;
    for (int ph = 0; ph < 5; ph++) begin
      write_min_distance(md_steps[ph]);
      in_idle_en = (ph != 2);
      out_idle_en = (ph != 2);
      for (k = 0; k < per_phase; k++) begin
        stim_row_t r;
        r = row_of(random_pose(), 0, 0, '0, '0);
        send_pose(r);
        if (ph == 1 && k == 100) begin
          // hold off until every pending request is out
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_requests.size() != 0);
        end else if (in_idle_en && $urandom_range(99) < 28) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
    end

    drain();
    if (errs == 0) begin
      $display("tb_hand_guiding_proximity_supervisor: done, clean");
    end else begin
      $display("tb_hand_guiding_proximity_supervisor: done, errors");
    end
    $finish;
  end

endmodule

>>> hand_guiding_proximity_supervisor.f
src/hgps_pkg.sv
src/hgps_datapath.sv
src/hgps_ctrl.sv
src/hand_guiding_proximity_supervisor.sv
bench/tb_hand_guiding_proximity_supervisor.sv
